>>> rtl/core/avg_pool_accumulate_scale_clamp_defines.svh
// assertion macros for the average pooling block
`ifndef AVG_POOL_ACCUMULATE_SCALE_CLAMP_DEFINES_SVH
`define AVG_POOL_ACCUMULATE_SCALE_CLAMP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define APASC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define APASC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/apasc_pkg.sv
// shared types and constants of the average pooling block
package apasc_pkg;

  localparam int MAX_CHANNELS_DEF = 256;
  localparam int ACC_WIDTH_DEF    = 32;

  localparam int SAMPLE_W   = 16;
  localparam int SCALE_W    = 17;
  localparam int SCALE_FRAC = 16;
  localparam int COUNT_W    = 9;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int FQ_DEPTH = 4;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_OUTPUT_MIN    = 2'd1,
    REG_OUTPUT_MAX    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]         channel_count;
    logic signed [SAMPLE_W-1:0] output_min;
    logic signed [SAMPLE_W-1:0] output_max;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_tap;
    logic                       last_tap;
    logic [SCALE_W-1:0]         scale;
    logic                       is_last_ch;
  } fe_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pooled;
    logic [CHAN_W-1:0]          channel;
    logic                       last_channel;
  } res_t;

  typedef struct packed {
    logic [OQ_CNT_W-1:0] oq_count;
    logic [1:0]          pending;
    logic                oq_push;
    logic                oq_full;
  } bk_status_t;

endpackage

>>> rtl/core/apasc_ram.sv
// generic single-port-write ram with registered read
module apasc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/apasc_fifo.sv
// small register fifo with occupancy count
module apasc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;

  assign count_nxt = count_r + CW'(push) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign count    = count_r;

endmodule

>>> rtl/core/apasc_front.sv
// front end: accepts samples, tracks channel position, queues work items
module apasc_front #(
  parameter int MAX_CHANNELS = apasc_pkg::MAX_CHANNELS_DEF,
  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  apasc_pkg::cfg_t                      cfg,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [apasc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_first_tap,
  input  logic                                 in_last_tap,
  input  logic [apasc_pkg::SCALE_W-1:0]        in_scale,
  output logic                                 fq_valid,
  output apasc_pkg::fe_item_t                  fq_item,
  output logic [POS_W-1:0]                     fq_pos,
  input  logic                                 fq_pop
);

  import apasc_pkg::*;

  localparam int CNT_W = (POS_W + 1 > COUNT_W) ? POS_W + 1 : COUNT_W;
  localparam int ENT_W = $bits(fe_item_t) + POS_W;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [CNT_W-1:0] eff_count;
  logic [CNT_W-1:0] pos_inc;
  logic             is_last_ch;
  logic             accept;
  logic             fq_full;
  logic             fq_empty;
  fe_item_t         item;
  logic [ENT_W-1:0] fq_rd;

  // zero acts as one, above capacity acts as capacity
  always_comb begin
    priority if (cfg.channel_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (CNT_W'(cfg.channel_count) > CNT_W'(MAX_CHANNELS)) begin
      eff_count = CNT_W'(MAX_CHANNELS);
    end else begin
      eff_count = CNT_W'(cfg.channel_count);
    end
  end

  assign accept     = in_valid && !in_stall;
  assign pos_inc    = CNT_W'(pos_r) + CNT_W'(1);
  assign is_last_ch = (pos_inc >= eff_count);
  assign pos_nxt    = accept ? (is_last_ch ? '0 : pos_inc[POS_W-1:0]) : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    item.sample     = in_sample;
    item.first_tap  = in_first_tap;
    item.last_tap   = in_last_tap;
    item.scale      = in_scale;
    item.is_last_ch = is_last_ch;
  end

  apasc_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (FQ_DEPTH)
  ) u_fq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data ({item, pos_r}),
    .pop       (fq_pop),
    .pop_data  (fq_rd),
    .empty     (fq_empty),
    .full      (fq_full),
    .count     ()
  );

  assign in_stall          = fq_full;
  assign fq_valid          = !fq_empty;
  assign {fq_item, fq_pos} = fq_rd;

endmodule

>>> rtl/core/apasc_back.sv
// back end: accumulator read-modify-write, scaling, clamp and result queue
module apasc_back #(
  parameter int MAX_CHANNELS = apasc_pkg::MAX_CHANNELS_DEF,
  parameter int ACC_WIDTH    = apasc_pkg::ACC_WIDTH_DEF,
  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  apasc_pkg::cfg_t        cfg,
  input  logic                   fq_valid,
  input  apasc_pkg::fe_item_t    fq_item,
  input  logic [POS_W-1:0]       fq_pos,
  output logic                   fq_pop,
  output logic                   res_valid,
  output apasc_pkg::res_t        res_data,
  input  logic                   res_pop,
  output apasc_pkg::bk_status_t  status
);

  import apasc_pkg::*;

  localparam int PROD_W = ACC_WIDTH + SCALE_W + 1;
  localparam int VAL_W  = PROD_W - SCALE_FRAC;
  localparam int WIDE_W = (POS_W > CHAN_W) ? POS_W : CHAN_W;

  // issue stage
  logic                    issue;
  logic [1:0]              pending;
  logic [OQ_CNT_W:0]       credit_sum;
  logic [OQ_CNT_W-1:0]     oq_count;
  logic                    oq_full;
  logic                    oq_empty;

  // accumulate stage
  logic                    s2_v_r;
  fe_item_t                s2_item_r;
  logic [POS_W-1:0]        s2_pos_r;
  logic                    fwd_hit_r;
  logic [ACC_WIDTH-1:0]    fwd_data_r;
  logic [ACC_WIDTH-1:0]    ram_rdata;
  logic [ACC_WIDTH-1:0]    old_acc;
  logic [ACC_WIDTH-1:0]    sample_ext;
  logic [ACC_WIDTH-1:0]    acc_sum;
  logic [WIDE_W-1:0]       pos_wide;

  // multiply stage
  logic                    s3_v_r;
  logic signed [ACC_WIDTH-1:0] s3_acc_r;
  logic [SCALE_W-1:0]      s3_scale_r;
  logic [CHAN_W-1:0]       s3_chan_r;
  logic                    s3_last_ch_r;
  logic signed [SCALE_W:0] scale_s;
  logic signed [PROD_W-1:0] product;

  // clamp stage
  logic                    s4_v_r;
  logic signed [PROD_W-1:0] s4_prod_r;
  logic [CHAN_W-1:0]       s4_chan_r;
  logic                    s4_last_ch_r;
  logic signed [VAL_W-1:0] value;
  logic signed [VAL_W-1:0] min_ext;
  logic signed [VAL_W-1:0] max_ext;
  logic signed [VAL_W-1:0] raised;
  logic signed [VAL_W-1:0] clamped;
  res_t                    res;

  // results in flight are reserved in the output queue before issue
  assign pending = 2'(s2_v_r && s2_item_r.last_tap) + 2'(s3_v_r) + 2'(s4_v_r);
  assign credit_sum = (OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(pending);
  assign issue  = fq_valid && (credit_sum < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign fq_pop = issue;

  apasc_ram #(
    .WIDTH (ACC_WIDTH),
    .DEPTH (MAX_CHANNELS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s2_v_r),
    .waddr (s2_pos_r),
    .wdata (acc_sum),
    .re    (issue),
    .raddr (fq_pos),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s2_v_r <= issue;
      s3_v_r <= s2_v_r && s2_item_r.last_tap;
      s4_v_r <= s3_v_r;
    end
  end

  // write landing in the same cycle as the read is forwarded
  always_ff @(posedge clk) begin
    s2_item_r  <= fq_item;
    s2_pos_r   <= fq_pos;
    fwd_hit_r  <= s2_v_r && (s2_pos_r == fq_pos);
    fwd_data_r <= acc_sum;
  end

  assign sample_ext = {{(ACC_WIDTH - SAMPLE_W){s2_item_r.sample[SAMPLE_W-1]}},
                       s2_item_r.sample};
  assign old_acc    = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign acc_sum    = s2_item_r.first_tap ? sample_ext : old_acc + sample_ext;
  assign pos_wide   = WIDE_W'(s2_pos_r);

  always_ff @(posedge clk) begin
    s3_acc_r     <= acc_sum;
    s3_scale_r   <= s2_item_r.scale;
    s3_chan_r    <= pos_wide[CHAN_W-1:0];
    s3_last_ch_r <= s2_item_r.is_last_ch;
  end

  assign scale_s = {1'b0, s3_scale_r};
  assign product = s3_acc_r * scale_s;

  always_ff @(posedge clk) begin
    s4_prod_r    <= product;
    s4_chan_r    <= s3_chan_r;
    s4_last_ch_r <= s3_last_ch_r;
  end

  // floor shift, raise to min then lower to max
  assign value   = s4_prod_r[PROD_W-1:SCALE_FRAC];
  assign min_ext = VAL_W'(cfg.output_min);
  assign max_ext = VAL_W'(cfg.output_max);
  assign raised  = (value < min_ext) ? min_ext : value;
  assign clamped = (raised > max_ext) ? max_ext : raised;

  always_comb begin
    res.pooled       = clamped[SAMPLE_W-1:0];
    res.channel      = s4_chan_r;
    res.last_channel = s4_last_ch_r;
  end

  apasc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OQ_DEPTH)
  ) u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s4_v_r),
    .push_data (res),
    .pop       (res_pop),
    .pop_data  (res_data),
    .empty     (oq_empty),
    .full      (oq_full),
    .count     (oq_count)
  );

  assign res_valid = !oq_empty;

  always_comb begin
    status.oq_count = oq_count;
    status.pending  = pending;
    status.oq_push  = s4_v_r;
    status.oq_full  = oq_full;
  end

endmodule

>>> rtl/core/avg_pool_accumulate_scale_clamp.sv
// average pooling top level: config registers, front end, back end
// throughput: one sample per cycle while the output queue drains, set by
//   the single accumulator ram whose read-modify-write runs one channel per cycle
//   with write forwarding
// reset: synchronous active-low rst_n clears queues, pipeline valids and channel
//   position, loads config register defaults; accumulator ram is not cleared
`include "avg_pool_accumulate_scale_clamp_defines.svh"
module avg_pool_accumulate_scale_clamp #(
  parameter int MAX_CHANNELS = apasc_pkg::MAX_CHANNELS_DEF,
  parameter int ACC_WIDTH    = apasc_pkg::ACC_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [apasc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                  in_first_tap,
  input  logic                                  in_last_tap,
  input  logic [apasc_pkg::SCALE_W-1:0]         in_scale,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [apasc_pkg::SAMPLE_W-1:0] out_pooled,
  output logic [apasc_pkg::CHAN_W-1:0]          out_channel,
  output logic                                  out_last_channel,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [apasc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [apasc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import apasc_pkg::*;

  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic             cfg_we;
  logic             fq_valid;
  fe_item_t         fq_item;
  logic [POS_W-1:0] fq_pos;
  logic             fq_pop;
  res_t             res_data;
  bk_status_t       bk_status;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHANNEL_COUNT: cfg_nxt.channel_count = cfg_data[COUNT_W-1:0];
        REG_OUTPUT_MIN:    cfg_nxt.output_min    = cfg_data;
        REG_OUTPUT_MAX:    cfg_nxt.output_max    = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count <= COUNT_W'(1);
      cfg_r.output_min    <= {1'b1, {(SAMPLE_W - 1){1'b0}}};
      cfg_r.output_max    <= {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  apasc_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_first_tap (in_first_tap),
    .in_last_tap  (in_last_tap),
    .in_scale     (in_scale),
    .fq_valid     (fq_valid),
    .fq_item      (fq_item),
    .fq_pos       (fq_pos),
    .fq_pop       (fq_pop)
  );

  apasc_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .fq_valid  (fq_valid),
    .fq_item   (fq_item),
    .fq_pos    (fq_pos),
    .fq_pop    (fq_pop),
    .res_valid (out_valid),
    .res_data  (res_data),
    .res_pop   (out_valid && !out_stall),
    .status    (bk_status)
  );

  assign out_pooled       = res_data.pooled;
  assign out_channel      = res_data.channel;
  assign out_last_channel = res_data.last_channel;

  // results in flight never exceed output queue space
  `APASC_ASSERT_IMP(a_credit_bound, 1'b1, int'(bk_status.oq_count) + int'(bk_status.pending) <= OQ_DEPTH, "output queue overcommitted")
  // a push never meets a full output queue
  `APASC_ASSERT_IMP(a_push_not_full, bk_status.oq_push, !bk_status.oq_full, "push into full output queue")
  // a pushed result is visible next cycle
  `APASC_ASSERT_NXT(a_push_visible, bk_status.oq_push, out_valid, "pushed result not presented")

endmodule

>>> verif/tb_top.sv
// testbench for the average pooling block: driven transactions checked against a predictor
module tb_top;
  import apasc_pkg::*;

  localparam int MAX_CH         = MAX_CHANNELS_DEF;
  localparam int ACC_W          = ACC_WIDTH_DEF;
  localparam int SETTLE_CYCLES  = 12;
  localparam int CYCLE_LIMIT    = 1000000;

  typedef enum {QUIET, SENDER_IDLE, RECEIVER_STALL, BOTH_IDLE} idle_mode_t;

  class pooled_average_checker;
    logic signed [ACC_W-1:0]    channel_totals[MAX_CH];
    bit                         total_written[MAX_CH];
    int unsigned                position;
    logic [COUNT_W-1:0]         channel_count;
    logic signed [SAMPLE_W-1:0] out_min;
    logic signed [SAMPLE_W-1:0] out_max;
    res_t                       expected_pooled_q[$];
    int                         failures;

    function new();
      position      = 0;
      channel_count = COUNT_W'(1);
      out_min       = -16'sd32768;
      out_max       = 16'sd32767;
      failures      = 0;
      foreach (total_written[i]) total_written[i] = 0;
    endfunction

    function void apply_setting(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CHANNEL_COUNT: channel_count = data[COUNT_W-1:0];
        REG_OUTPUT_MIN:    out_min = data;
        REG_OUTPUT_MAX:    out_max = data;
        default: ;
      endcase
    endfunction

    function int unsigned effective_count();
      if (channel_count == 0) return 1;
      if (channel_count > MAX_CH) return MAX_CH;
      return channel_count;
    endfunction

    function bit at_row_end();
      return (position + 1) >= effective_count();
    endfunction

    function bit current_written();
      return total_written[position % MAX_CH];
    endfunction

    function int pending();
      return expected_pooled_q.size();
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] sample, logic first_tap,
                              logic last_tap, logic [SCALE_W-1:0] scale);
      int unsigned             idx;
      bit                      row_end;
      logic signed [ACC_W-1:0] total;
      longint                  product;
      longint                  value;
      res_t                    res;
      idx     = position % MAX_CH;
      row_end = at_row_end();
      if (first_tap) begin
        total = ACC_W'(sample);
        total_written[idx] = 1;
      end else begin
        total = channel_totals[idx] + ACC_W'(sample);
      end
      channel_totals[idx] = total;
      if (last_tap) begin
        product = longint'(total) * longint'(scale);
        value   = product >>> SCALE_FRAC;
        if (value < longint'(out_min)) value = longint'(out_min);
        if (value > longint'(out_max)) value = longint'(out_max);
        res.pooled       = value[SAMPLE_W-1:0];
        res.channel      = idx[CHAN_W-1:0];
        res.last_channel = row_end;
        expected_pooled_q.push_back(res);
      end
      position = row_end ? 0 : position + 1;
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] pooled, logic [CHAN_W-1:0] channel,
                               logic last_channel);
      res_t exp_res;
      if (expected_pooled_q.size() == 0) begin
        $error("unexpected result: pooled %0d channel %0d", pooled, channel);
        failures++;
        return;
      end
      exp_res = expected_pooled_q.pop_front();
      if (exp_res.pooled !== pooled) begin
        $error("pooled: expected %0d, actual %0d", exp_res.pooled, pooled);
        failures++;
      end
      if (exp_res.channel !== channel) begin
        $error("channel: expected %0d, actual %0d", exp_res.channel, channel);
        failures++;
      end
      if (exp_res.last_channel !== last_channel) begin
        $error("last_channel: expected %0d, actual %0d", exp_res.last_channel, last_channel);
        failures++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [SAMPLE_W-1:0]   in_sample;
  logic                         in_first_tap;
  logic                         in_last_tap;
  logic [SCALE_W-1:0]           in_scale;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [SAMPLE_W-1:0]   out_pooled;
  logic [CHAN_W-1:0]            out_channel;
  logic                         out_last_channel;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  pooled_average_checker sb;
  idle_mode_t            idle_mode;
  int                    cycle_count;

  avg_pool_accumulate_scale_clamp dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_first_tap     (in_first_tap),
    .in_last_tap      (in_last_tap),
    .in_scale         (in_scale),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pooled       (out_pooled),
    .out_channel      (out_channel),
    .out_last_channel (out_last_channel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL avg_pool_accumulate_scale_clamp");
      $finish;
    end
  end

  // receiver side
  always @(negedge clk) begin
    case (idle_mode)
      RECEIVER_STALL: out_stall = ($urandom_range(0, 99) < 71);
      BOTH_IDLE:      out_stall = ($urandom_range(0, 99) < 24);
      default:        out_stall = 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_pooled, out_channel, out_last_channel);
    end
  end

  function automatic int sender_idle_pct();
    case (idle_mode)
      SENDER_IDLE: return 71;
      BOTH_IDLE:   return 24;
      default:     return 0;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // all tasks start and end just after a falling edge
  task automatic drive_sample(input logic signed [SAMPLE_W-1:0] sample, input logic first_tap,
                              input logic last_tap, input logic [SCALE_W-1:0] scale);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_sample    = sample;
    in_first_tap = first_tap;
    in_last_tap  = last_tap;
    in_scale     = scale;
    do @(posedge clk); while (in_stall);
    sb.note_sample(sample, first_tap, last_tap, scale);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    in_valid  = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_setting(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic settle_block();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input int count, input logic signed [SAMPLE_W-1:0] lo,
                                input logic signed [SAMPLE_W-1:0] hi);
    settle_block();
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(count));
    write_reg(REG_OUTPUT_MIN, lo);
    write_reg(REG_OUTPUT_MAX, hi);
  endtask

  // mostly well-formed pooling windows, some noise transactions
  task automatic run_random_phase(input int n_items);
    int                         taps;
    int                         tap;
    logic [SCALE_W-1:0]         win_scale;
    logic [SCALE_W-1:0]         scale;
    logic                       first_tap;
    logic                       last_tap;
    bit                         row_end;
    taps = 0;
    tap  = 0;
    win_scale = '0;
    for (int i = 0; i < n_items; i++) begin
      if (tap >= taps) begin
        taps = $urandom_range(1, (sb.effective_count() > 16) ? 2 : 9);
        tap  = 0;
        win_scale = SCALE_W'(65536 / taps);
        if ($urandom_range(0, 9) == 0) win_scale = SCALE_W'($urandom_range(0, 131071));
      end
      row_end = sb.at_row_end();
      if ($urandom_range(0, 99) < 85) begin
        first_tap = (tap == 0);
        last_tap  = (tap == taps - 1);
        scale     = win_scale;
      end else begin
        first_tap = 1'($urandom_range(0, 1));
        last_tap  = 1'($urandom_range(0, 1));
        scale     = SCALE_W'($urandom_range(0, 131071));
      end
      // never read an accumulator that was not loaded
      if (!sb.current_written()) first_tap = 1'b1;
      drive_sample(pick_sample(), first_tap, last_tap, scale);
      if (row_end) tap++;
      if ($urandom_range(0, 299) == 0) wait_for_results();
    end
  endtask

  task automatic run_phase(input int count, input logic signed [SAMPLE_W-1:0] lo,
                           input logic signed [SAMPLE_W-1:0] hi, input idle_mode_t mode,
                           input int n_items);
    apply_settings(count, lo, hi);
    idle_mode = mode;
    run_random_phase(n_items);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    sb           = new();
    idle_mode    = QUIET;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    in_first_tap = 1'b0;
    in_last_tap  = 1'b0;
    in_scale     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_CHANNEL_COUNT;
    cfg_data     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single-tap windows at reset settings, field extremes
    drive_sample(16'sh7fff, 1'b1, 1'b1, 17'd65536);
    drive_sample(16'sh8000, 1'b1, 1'b1, 17'd65536);
    drive_sample(16'sd12345, 1'b1, 1'b1, 17'd0);
    drive_sample(16'sd1, 1'b1, 1'b1, 17'h1ffff);
    drive_sample(-16'sd1, 1'b1, 1'b1, 17'd1);
    drive_sample(16'sh8000, 1'b1, 1'b1, 17'h1ffff);
    // multi-tap windows
    drive_sample(16'sd100, 1'b1, 1'b0, 17'd0);
    drive_sample(16'sd200, 1'b0, 1'b0, 17'd0);
    drive_sample(-16'sd50, 1'b0, 1'b0, 17'd0);
    drive_sample(16'sd300, 1'b0, 1'b1, 17'd32768);
    drive_sample(16'sh8000, 1'b1, 1'b0, 17'd65536);
    drive_sample(16'sh8000, 1'b0, 1'b1, 17'd65536);

    // channel count lowered in the middle of a pixel
    apply_settings(4, -16'sd32768, 16'sd32767);
    for (int c = 0; c < 3; c++) drive_sample(16'sd1000 + 16'(c), 1'b1, 1'b0, 17'd65536);
    apply_settings(2, -16'sd32768, 16'sd32767);
    drive_sample(16'sd777, 1'b1, 1'b1, 17'd65536);
    drive_sample(16'sd5, 1'b1, 1'b1, 17'd65536);
    drive_sample(16'sd6, 1'b1, 1'b1, 17'd65536);

    // inverted clamp bounds
    apply_settings(1, 16'sd100, -16'sd100);
    drive_sample(16'sd5000, 1'b1, 1'b1, 17'd65536);
    drive_sample(-16'sd5000, 1'b1, 1'b1, 17'd65536);

    run_phase(3, -16'sd32768, 16'sd32767, QUIET, 60);
    run_phase(5, -16'sd1000, 16'sd1000, SENDER_IDLE, 60);
    lo = SAMPLE_W'($urandom);
    hi = SAMPLE_W'($urandom);
    run_phase(2, lo, hi, RECEIVER_STALL, 60);
    run_phase(1, 16'sd32767, 16'sd32767, BOTH_IDLE, 40);
    run_phase(0, -16'sd32768, -16'sd32768, QUIET, 30);
    lo = SAMPLE_W'($urandom);
    hi = SAMPLE_W'($urandom);
    if (lo > hi) run_phase(7, hi, lo, BOTH_IDLE, 60);
    else run_phase(7, lo, hi, BOTH_IDLE, 60);
    run_phase(256, -16'sd32768, 16'sd32767, SENDER_IDLE, 260);
    run_phase(300, -16'sd256, 16'sd256, RECEIVER_STALL, 40);
    run_phase(511, -16'sd32768, 16'sd32767, QUIET, 30);
    run_phase(4, -16'sd20000, 16'sd20000, BOTH_IDLE, 50);

    settle_block();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS avg_pool_accumulate_scale_clamp");
    end else begin
      $display("FAIL avg_pool_accumulate_scale_clamp");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/apasc_pkg.sv
rtl/core/apasc_ram.sv
rtl/core/apasc_fifo.sv
rtl/core/apasc_front.sv
rtl/core/apasc_back.sv
rtl/core/avg_pool_accumulate_scale_clamp.sv
verif/tb_top.sv
